// ===== sv/jva_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types and helper functions for the Jones visibility correction block.
// Depends on nothing; jva_ram aside, files refer to it by scoped names or import it.
package jva_pkg;

    localparam int NUM_STATIONS = 64;
    localparam int DATA_W       = 24;
    localparam int COEF_W       = 18;
    localparam int COEF_FRAC    = 14;
    localparam int STATION_W    = 6;
    localparam int ENTRY_SEL_W  = 2;
    localparam int NUM_ENTRIES  = 4;
    localparam int NUM_VIS      = 8;
    localparam int ADDR_W       = $clog2(NUM_STATIONS);
    localparam int ENT_W        = 2 * COEF_W;

    // Conjugated coefficients carry one extra bit so that negating the most
    // negative imaginary part stays exact.
    localparam int JQ_W    = COEF_W + 1;
    localparam int PR1_W   = JQ_W + DATA_W;
    localparam int SUM1_W  = PR1_W + 2;
    localparam int T_W     = SUM1_W - COEF_FRAC;
    localparam int PR2_W   = COEF_W + T_W;
    localparam int SUM2_W  = PR2_W + 2;
    localparam int R_W     = SUM2_W - COEF_FRAC;

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = NUM_VIS * DATA_W;
    localparam int VIS_LSB     = 2 * STATION_W + ENTRY_SEL_W;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [NUM_VIS-1:0][DATA_W-1:0] vis_vec_t;
    typedef logic [NUM_ENTRIES-1:0][ENT_W-1:0] jones_row_t;

    typedef struct packed {
        logic                   en;
        logic [STATION_W-1:0]   station;
        logic [ENTRY_SEL_W-1:0] entry;
        logic [ENT_W-1:0]       data;
    } tbl_wr_t;

    function automatic data_t sat_data(input logic signed [R_W-1:0] x);
        logic signed [R_W-1:0] hi;
        logic signed [R_W-1:0] lo;
        hi = R_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - R_W'(1);
        if (x > hi) begin
            sat_data = data_t'(hi);
        end else if (x < lo) begin
            sat_data = data_t'(lo);
        end else begin
            sat_data = data_t'(x);
        end
    endfunction

    function automatic logic station_ok(input logic [STATION_W-1:0] st);
        station_ok = ({1'b0, st} < (STATION_W+1)'(NUM_STATIONS));
    endfunction

endpackage

// ===== sv/jva_ram.sv =====
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Depends on nothing.
module jva_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== sv/jva_table.sv =====
`timescale 1ns / 1ps
// Jones matrix table: one RAM per matrix entry, each read at both stations of a baseline.
// Depends on jva_pkg and jva_ram.
module jva_table (
    input  logic                           aclk,
    input  jva_pkg::tbl_wr_t               wr,
    input  logic                           rd_en,
    input  logic [jva_pkg::STATION_W-1:0]  rd_p,
    input  logic [jva_pkg::STATION_W-1:0]  rd_q,
    output jva_pkg::jones_row_t            jp_row,
    output jva_pkg::jones_row_t            jq_row
);

    logic wr_ok;

    assign wr_ok = wr.en && jva_pkg::station_ok(wr.station);

    for (genvar k = 0; k < jva_pkg::NUM_ENTRIES; k++) begin : g_entry
        jva_ram #(
            .WIDTH(jva_pkg::ENT_W),
            .DEPTH(jva_pkg::NUM_STATIONS)
        ) u_ram (
            .aclk   (aclk),
            .we     (wr_ok && (wr.entry == jva_pkg::ENTRY_SEL_W'(k))),
            .waddr  (wr.station[jva_pkg::ADDR_W-1:0]),
            .wdata  (wr.data),
            .re     (rd_en),
            .raddr_a(rd_p[jva_pkg::ADDR_W-1:0]),
            .raddr_b(rd_q[jva_pkg::ADDR_W-1:0]),
            .rdata_a(jp_row[k]),
            .rdata_b(jq_row[k])
        );
    end

endmodule

// ===== sv/jva_datapath.sv =====
`timescale 1ns / 1ps
// Five-stage arithmetic pipeline: V * conj(Jq)^T, then Jp * T, rounding and saturation.
// Depends on jva_pkg; takes the table rows from the registered read data of the table.
module jva_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_apply,
    input  logic [jva_pkg::STATION_W-1:0] in_p,
    input  logic [jva_pkg::STATION_W-1:0] in_q,
    input  jva_pkg::vis_vec_t             in_vis,
    input  jva_pkg::jones_row_t           jp_row,
    input  jva_pkg::jones_row_t           jq_row,
    output logic                          en1,
    input  logic                          m_ready,
    output logic                          m_valid,
    output jva_pkg::vis_vec_t             m_data
);

    logic en2, en3, en4, en5;

    // Stage 1: table read in flight.
    logic v1_reg, byp1_reg, pok1_reg, qok1_reg;
    jva_pkg::vis_vec_t vis1_reg;

    // Stage 2: first products.
    logic v2_reg, byp2_reg;
    jva_pkg::vis_vec_t vis2_reg;
    jva_pkg::coef_t jp2_re_reg [4];
    jva_pkg::coef_t jp2_im_reg [4];
    logic signed [jva_pkg::PR1_W-1:0] pr1_reg [8][4];

    // Stage 3: T rounded.
    logic v3_reg, byp3_reg;
    jva_pkg::vis_vec_t vis3_reg;
    jva_pkg::coef_t jp3_re_reg [4];
    jva_pkg::coef_t jp3_im_reg [4];
    logic signed [jva_pkg::T_W-1:0] t_re_reg [4];
    logic signed [jva_pkg::T_W-1:0] t_im_reg [4];

    // Stage 4: second products.
    logic v4_reg, byp4_reg;
    jva_pkg::vis_vec_t vis4_reg;
    logic signed [jva_pkg::PR2_W-1:0] pr2_reg [8][4];

    // Stage 5: result register.
    logic vo_reg;
    jva_pkg::vis_vec_t out_reg;

    assign en5 = !vo_reg || m_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_apply;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            byp1_reg <= (in_p == in_q);
            pok1_reg <= jva_pkg::station_ok(in_p);
            qok1_reg <= jva_pkg::station_ok(in_q);
            vis1_reg <= in_vis;
        end
    end

    // Stage 2: eight complex products. Product m belongs to T[m/2], term m%2;
    // T[2i+j] = V[i][0]*conj(Jq[j][0]) + V[i][1]*conj(Jq[j][1]).
    always_ff @(posedge aclk) begin
        logic signed [jva_pkg::JQ_W-1:0] qre [4];
        logic signed [jva_pkg::JQ_W-1:0] qim [4];
        logic signed [jva_pkg::JQ_W-1:0] ar, ai;
        jva_pkg::data_t br, bi;
        if (en2) begin
            byp2_reg <= byp1_reg;
            vis2_reg <= vis1_reg;
            for (int k = 0; k < 4; k++) begin
                jp2_re_reg[k] <= pok1_reg ? jva_pkg::coef_t'(jp_row[k][jva_pkg::COEF_W-1:0])
                                          : '0;
                jp2_im_reg[k] <= pok1_reg ?
                    jva_pkg::coef_t'(jp_row[k][jva_pkg::ENT_W-1:jva_pkg::COEF_W]) : '0;
                qre[k] = qok1_reg ?
                    jva_pkg::JQ_W'(jva_pkg::coef_t'(jq_row[k][jva_pkg::COEF_W-1:0])) : '0;
                qim[k] = qok1_reg ?
                    -jva_pkg::JQ_W'(jva_pkg::coef_t'(jq_row[k][jva_pkg::ENT_W-1:jva_pkg::COEF_W]))
                    : '0;
            end
            for (int m = 0; m < 8; m++) begin
                ar = qre[2 * ((m / 2) % 2) + (m % 2)];
                ai = qim[2 * ((m / 2) % 2) + (m % 2)];
                br = jva_pkg::data_t'(vis1_reg[2 * (2 * (m / 4) + (m % 2))]);
                bi = jva_pkg::data_t'(vis1_reg[2 * (2 * (m / 4) + (m % 2)) + 1]);
                pr1_reg[m][0] <= jva_pkg::PR1_W'(ar) * jva_pkg::PR1_W'(br);
                pr1_reg[m][1] <= jva_pkg::PR1_W'(ai) * jva_pkg::PR1_W'(bi);
                pr1_reg[m][2] <= jva_pkg::PR1_W'(ar) * jva_pkg::PR1_W'(bi);
                pr1_reg[m][3] <= jva_pkg::PR1_W'(ai) * jva_pkg::PR1_W'(br);
            end
        end
    end

    // Stage 3: sum, round half up.
    always_ff @(posedge aclk) begin
        logic signed [jva_pkg::SUM1_W-1:0] sre, sim;
        if (en3) begin
            byp3_reg <= byp2_reg;
            vis3_reg <= vis2_reg;
            jp3_re_reg <= jp2_re_reg;
            jp3_im_reg <= jp2_im_reg;
            for (int t = 0; t < 4; t++) begin
                sre = jva_pkg::SUM1_W'(pr1_reg[2*t][0]) - jva_pkg::SUM1_W'(pr1_reg[2*t][1])
                    + jva_pkg::SUM1_W'(pr1_reg[2*t+1][0]) - jva_pkg::SUM1_W'(pr1_reg[2*t+1][1])
                    + jva_pkg::SUM1_W'(1 << (jva_pkg::COEF_FRAC - 1));
                sim = jva_pkg::SUM1_W'(pr1_reg[2*t][2]) + jva_pkg::SUM1_W'(pr1_reg[2*t][3])
                    + jva_pkg::SUM1_W'(pr1_reg[2*t+1][2]) + jva_pkg::SUM1_W'(pr1_reg[2*t+1][3])
                    + jva_pkg::SUM1_W'(1 << (jva_pkg::COEF_FRAC - 1));
                t_re_reg[t] <= sre[jva_pkg::SUM1_W-1:jva_pkg::COEF_FRAC];
                t_im_reg[t] <= sim[jva_pkg::SUM1_W-1:jva_pkg::COEF_FRAC];
            end
        end
    end

    // Stage 4: R[2i+j] = Jp[i][0]*T[j] + Jp[i][1]*T[2+j]; product m is R[m/2], term m%2.
    always_ff @(posedge aclk) begin
        jva_pkg::coef_t ar, ai;
        logic signed [jva_pkg::T_W-1:0] br, bi;
        if (en4) begin
            byp4_reg <= byp3_reg;
            vis4_reg <= vis3_reg;
            for (int m = 0; m < 8; m++) begin
                ar = jp3_re_reg[2 * (m / 4) + (m % 2)];
                ai = jp3_im_reg[2 * (m / 4) + (m % 2)];
                br = t_re_reg[2 * (m % 2) + ((m / 2) % 2)];
                bi = t_im_reg[2 * (m % 2) + ((m / 2) % 2)];
                pr2_reg[m][0] <= jva_pkg::PR2_W'(ar) * jva_pkg::PR2_W'(br);
                pr2_reg[m][1] <= jva_pkg::PR2_W'(ai) * jva_pkg::PR2_W'(bi);
                pr2_reg[m][2] <= jva_pkg::PR2_W'(ar) * jva_pkg::PR2_W'(bi);
                pr2_reg[m][3] <= jva_pkg::PR2_W'(ai) * jva_pkg::PR2_W'(br);
            end
        end
    end

    // Stage 5: sum, round, saturate, or pass the data through for equal stations.
    always_ff @(posedge aclk) begin
        logic signed [jva_pkg::SUM2_W-1:0] sre, sim;
        if (en5) begin
            for (int r = 0; r < 4; r++) begin
                sre = jva_pkg::SUM2_W'(pr2_reg[2*r][0]) - jva_pkg::SUM2_W'(pr2_reg[2*r][1])
                    + jva_pkg::SUM2_W'(pr2_reg[2*r+1][0]) - jva_pkg::SUM2_W'(pr2_reg[2*r+1][1])
                    + jva_pkg::SUM2_W'(1 << (jva_pkg::COEF_FRAC - 1));
                sim = jva_pkg::SUM2_W'(pr2_reg[2*r][2]) + jva_pkg::SUM2_W'(pr2_reg[2*r][3])
                    + jva_pkg::SUM2_W'(pr2_reg[2*r+1][2]) + jva_pkg::SUM2_W'(pr2_reg[2*r+1][3])
                    + jva_pkg::SUM2_W'(1 << (jva_pkg::COEF_FRAC - 1));
                if (byp4_reg) begin
                    out_reg[2*r]   <= vis4_reg[2*r];
                    out_reg[2*r+1] <= vis4_reg[2*r+1];
                end else begin
                    out_reg[2*r]   <= jva_pkg::sat_data(sre[jva_pkg::SUM2_W-1:jva_pkg::COEF_FRAC]);
                    out_reg[2*r+1] <= jva_pkg::sat_data(sim[jva_pkg::SUM2_W-1:jva_pkg::COEF_FRAC]);
                end
            end
        end
    end

    assign m_valid = vo_reg;
    assign m_data  = out_reg;

endmodule

// ===== sv/jones_visibility_apply.sv =====
`timescale 1ns / 1ps
// Top level of the Jones matrix visibility correction block.
// Depends on jva_pkg, jva_table (with jva_ram) and jva_datapath.

// Applies per-station 2x2 complex Jones matrices to one channel of visibilities
// per request, returning Jp * V * conj(Jq)^T, or V unchanged when both stations of
// the baseline are the same. A request with s_tuser low writes one matrix entry
// (station in station_p, entry in entry_index, Q3.14 value in xx_re/xx_im) and
// yields no result; a request with s_tuser high applies the matrices and yields one
// result. The block takes one request per cycle for as long as the result side
// keeps up: the table is held in four single-write, dual-read RAMs, one per matrix
// entry, so both stations of a baseline are looked up in the same cycle. The
// pipeline has five stages (one of table read, two per matrix product); the read
// stage loads on the accepting edge, and the request then moves on through the
// later stages unless the result side stalls. A write is visible to any apply
// request accepted in a later cycle. Entries that were never written read as
// undefined data; there is no clearing pass after reset.
module jones_visibility_apply (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // station_p, station_q, entry_index, xx_re, xx_im, xy_re, xy_im,
    // yx_re, yx_im, yy_re, yy_im, then two zero bits
    input  logic [jva_pkg::IN_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_xx_re, out_xx_im, out_xy_re, out_xy_im,
    // out_yx_re, out_yx_im, out_yy_re, out_yy_im
    output logic [jva_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic                          s_fire;
    logic                          rd_en;
    logic [jva_pkg::STATION_W-1:0] st_p;
    logic [jva_pkg::STATION_W-1:0] st_q;
    jva_pkg::vis_vec_t             vis_in;
    jva_pkg::vis_vec_t             vis_out;
    jva_pkg::tbl_wr_t              wr;
    jva_pkg::jones_row_t           jp_row;
    jva_pkg::jones_row_t           jq_row;

    assign st_p   = s_tdata[jva_pkg::STATION_W-1:0];
    assign st_q   = s_tdata[2*jva_pkg::STATION_W-1:jva_pkg::STATION_W];
    assign vis_in = s_tdata[jva_pkg::VIS_LSB +: jva_pkg::OUT_TDATA_W];

    // The request is taken whenever the first pipeline stage can move.
    assign s_tready = rd_en;
    assign s_fire   = s_tvalid && s_tready;

    // A write request stores the low coefficient bits of xx_re and xx_im.
    assign wr.en      = s_fire && !s_tuser;
    assign wr.station = st_p;
    assign wr.entry   = s_tdata[jva_pkg::VIS_LSB-1:2*jva_pkg::STATION_W];
    assign wr.data    = {s_tdata[jva_pkg::VIS_LSB + jva_pkg::DATA_W +: jva_pkg::COEF_W],
                         s_tdata[jva_pkg::VIS_LSB +: jva_pkg::COEF_W]};

    jva_table u_table (
        .aclk  (aclk),
        .wr    (wr),
        .rd_en (rd_en),
        .rd_p  (st_p),
        .rd_q  (st_q),
        .jp_row(jp_row),
        .jq_row(jq_row)
    );

    jva_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_apply(s_fire && s_tuser),
        .in_p    (st_p),
        .in_q    (st_q),
        .in_vis  (vis_in),
        .jp_row  (jp_row),
        .jq_row  (jq_row),
        .en1     (rd_en),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_data  (vis_out)
    );

    assign m_tdata = vis_out;

    // With the result register empty, every stage can move, so input is taken.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the result register is empty");

    // An apply request is offered as a result if the result side does not stall meanwhile.
    a_apply_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) ##1 m_tready ##1 m_tready ##1 m_tready
            ##1 m_tready |=> m_tvalid)
        else $error("apply request did not produce a result in time");

endmodule

// ===== tb/tb_jones_visibility_apply.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Jones matrix visibility correction block.
// Depends on jva_pkg and jones_visibility_apply; a small class predicts and checks results.

import jva_pkg::*;

// Holds a mirror of the Jones table and the queue of corrected visibilities that
// the block still owes us.
class jones_scoreboard;
    longint coef_re [NUM_STATIONS*NUM_ENTRIES];
    longint coef_im [NUM_STATIONS*NUM_ENTRIES];
    vis_vec_t pending_vis [$];
    int errors;

    function new();
        errors = 0;
        for (int i = 0; i < NUM_STATIONS*NUM_ENTRIES; i++) begin
            coef_re[i] = 0;
            coef_im[i] = 0;
        end
    endfunction

    // Round half up by the coefficient fraction; >>> floors on signed values.
    static function longint round_frac(longint x);
        longint r;
        r = x + (longint'(1) << (COEF_FRAC - 1));
        return r >>> COEF_FRAC;
    endfunction

    static function logic [DATA_W-1:0] clip(longint x);
        longint hi;
        hi = (longint'(1) << (DATA_W - 1)) - 1;
        if (x > hi) x = hi;
        if (x < -hi - 1) x = -hi - 1;
        return x[DATA_W-1:0];
    endfunction

    // a*b + c*d over complex pairs, then rounded.
    static function void mac2(input longint ar, ai, br, bi, cr, ci, dr, di,
                              output longint rr, ri);
        rr = round_frac(ar*br - ai*bi + cr*dr - ci*di);
        ri = round_frac(ar*bi + ai*br + cr*di + ci*dr);
    endfunction

    function void note_request(logic mode, logic [5:0] sp, logic [5:0] sq,
                               logic [1:0] ent, vis_vec_t vis);
        longint vr [4], vi [4], pr [4], pi [4], qr [4], qi [4];
        longint tr [4], ti [4], rr [4], ri [4];
        vis_vec_t res;
        coef_t c;
        if (!mode) begin
            if (sp < NUM_STATIONS) begin
                c = vis[0][COEF_W-1:0];
                coef_re[sp*4+ent] = c;
                c = vis[1][COEF_W-1:0];
                coef_im[sp*4+ent] = c;
            end
            return;
        end
        for (int k = 0; k < 4; k++) begin
            vr[k] = data_t'(vis[2*k]);
            vi[k] = data_t'(vis[2*k+1]);
            pr[k] = coef_re[sp*4+k];
            pi[k] = coef_im[sp*4+k];
            qr[k] = coef_re[sq*4+k];
            qi[k] = -coef_im[sq*4+k];
        end
        if (sp == sq) begin
            for (int k = 0; k < 4; k++) begin
                rr[k] = vr[k];
                ri[k] = vi[k];
            end
        end else begin
            mac2(qr[0], qi[0], vr[0], vi[0], qr[1], qi[1], vr[1], vi[1], tr[0], ti[0]);
            mac2(qr[2], qi[2], vr[0], vi[0], qr[3], qi[3], vr[1], vi[1], tr[1], ti[1]);
            mac2(qr[0], qi[0], vr[2], vi[2], qr[1], qi[1], vr[3], vi[3], tr[2], ti[2]);
            mac2(qr[2], qi[2], vr[2], vi[2], qr[3], qi[3], vr[3], vi[3], tr[3], ti[3]);
            mac2(pr[0], pi[0], tr[0], ti[0], pr[1], pi[1], tr[2], ti[2], rr[0], ri[0]);
            mac2(pr[0], pi[0], tr[1], ti[1], pr[1], pi[1], tr[3], ti[3], rr[1], ri[1]);
            mac2(pr[2], pi[2], tr[0], ti[0], pr[3], pi[3], tr[2], ti[2], rr[2], ri[2]);
            mac2(pr[2], pi[2], tr[1], ti[1], pr[3], pi[3], tr[3], ti[3], rr[3], ri[3]);
        end
        for (int k = 0; k < 4; k++) begin
            res[2*k]   = clip(rr[k]);
            res[2*k+1] = clip(ri[k]);
        end
        pending_vis.push_back(res);
    endfunction

    function void check_result(vis_vec_t got);
        vis_vec_t want;
        string names [8] = '{"out_xx_re", "out_xx_im", "out_xy_re", "out_xy_im",
                             "out_yx_re", "out_yx_im", "out_yy_re", "out_yy_im"};
        if (pending_vis.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        want = pending_vis.pop_front();
        for (int k = 0; k < 8; k++) begin
            if (want[k] !== got[k]) begin
                $error("%s: expected %0d, actual %0d", names[k],
                       data_t'(want[k]), data_t'(got[k]));
                errors++;
            end
        end
    endfunction
endclass

module tb_jones_visibility_apply;
    localparam int WATCHDOG_LIMIT = 2000;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    jones_scoreboard board;
    int idle_cycles;
    int results_seen;
    int requests_sent;
    // While set, both sides stop idling.
    bit steady_flow;
    // Stations whose four entries have all been written; only these are applied.
    bit loaded [NUM_STATIONS];
    int loaded_list [$];

    jones_visibility_apply uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: sample on the edge, check accepted results, and stall at random unless steady_flow.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata);
                results_seen++;
            end
            m_tready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 36);
        end
    end

    // The watchdog counts cycles in which no request and no result was accepted.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     board.pending_vis.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Drives one request, holding it until the block accepts it, and notes it.
    task automatic send_request(logic mode, logic [5:0] sp, logic [5:0] sq,
                                logic [1:0] ent, vis_vec_t vis);
        while (!steady_flow && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, vis, ent, sq, sp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(mode, sp, sq, ent, vis);
        requests_sent++;
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
    endtask

    function automatic logic [DATA_W-1:0] random_data();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(DATA_W-1){1'b1}}};
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2: return DATA_W'($urandom_range(0, 200)) - DATA_W'(100);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Coefficients mostly in [-1, 1]; else full scale, or wide values whose upper bits wrap.
    function automatic vis_vec_t random_coef();
        vis_vec_t v;
        for (int k = 0; k < 8; k++) v[k] = DATA_W'($urandom);
        case ($urandom_range(0, 4))
            0: begin
                v[0] = DATA_W'($urandom);
                v[1] = DATA_W'($urandom);
            end
            1: begin
                v[0] = DATA_W'(18'sh1ffff);
                v[1] = DATA_W'(-18'sh20000);
            end
            default: begin
                v[0] = DATA_W'($urandom_range(0, 32768)) - DATA_W'(16384);
                v[1] = DATA_W'($urandom_range(0, 32768)) - DATA_W'(16384);
            end
        endcase
        return v;
    endfunction

    function automatic vis_vec_t random_vis();
        vis_vec_t v;
        for (int k = 0; k < 8; k++) v[k] = random_data();
        return v;
    endfunction

    task automatic load_station(int st, vis_vec_t coef [4]);
        for (int e = 0; e < 4; e++) begin
            send_request(1'b0, st[5:0], 6'($urandom), e[1:0], coef[e]);
        end
        if (!loaded[st]) begin
            loaded[st] = 1'b1;
            loaded_list.push_back(st);
        end
    endtask

    task automatic apply_random();
        int p, q;
        p = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        q = ($urandom_range(0, 9) == 0) ? p
                                        : loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        send_request(1'b1, p[5:0], q[5:0], 2'($urandom), random_vis());
    endtask

    initial begin
        vis_vec_t coef [4];
        vis_vec_t vis;
        board = new();
        idle_cycles = 0;
        results_seen = 0;
        requests_sent = 0;
        steady_flow = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: an identity matrix, a full-scale one and one too wide for the table.
        for (int e = 0; e < 4; e++) coef[e] = '0;
        coef[0][0] = DATA_W'(16384);
        coef[3][0] = DATA_W'(16384);
        load_station(0, coef);
        for (int e = 0; e < 4; e++) begin
            coef[e] = '0;
            coef[e][0] = DATA_W'(18'sh1ffff);
            coef[e][1] = DATA_W'(-18'sh20000);
        end
        load_station(63, coef);
        // Coefficient too wide for the table: upper bits are dropped.
        for (int e = 0; e < 4; e++) begin
            coef[e] = '0;
            coef[e][0] = 24'h7fffff;
            coef[e][1] = 24'h800000;
        end
        load_station(5, coef);
        vis = '0;
        for (int k = 0; k < 8; k++) vis[k] = (k % 2) ? 24'h800000 : 24'h7fffff;
        send_request(1'b1, 6'd0, 6'd63, 2'd3, vis);   // saturates hard
        send_request(1'b1, 6'd63, 6'd0, 2'd0, vis);
        send_request(1'b1, 6'd63, 6'd63, 2'd1, vis);  // equal stations pass through
        send_request(1'b1, 6'd5, 6'd63, 2'd2, vis);
        send_request(1'b1, 6'd0, 6'd5, 2'd0, '0);
        vis = '1;
        send_request(1'b1, 6'd5, 6'd0, 2'd0, vis);
        finish_sending();

        // Hold off until everything owed has come back.
        while (board.pending_vis.size() != 0) @(posedge aclk);

        // Random part: reload matrices now and then, mostly apply.
        while (requests_sent < 880) begin
            steady_flow = (requests_sent >= 400 && requests_sent < 520);
            if (loaded_list.size() < 4 || $urandom_range(0, 19) == 0) begin
                for (int e = 0; e < 4; e++) coef[e] = random_coef();
                load_station($urandom_range(0, NUM_STATIONS - 1), coef);
            end else begin
                apply_random();
            end
        end
        steady_flow = 1'b0;
        finish_sending();

        while (board.pending_vis.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d requests (table writes and corrections) and checked %0d results.",
                 requests_sent, results_seen);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
